// ----- sv/atcd_pkg.sv -----
package atcd_pkg;

	// Cell store geometry
	localparam int NUM_CELLS = 4096;
	localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	// Field widths
	localparam int CIDX_W    = 12;
	localparam int V_W       = 24;
	localparam int START_W   = 40;
	localparam int LEN_W     = 24;
	localparam int ACT_W     = 41;

	// Q0.16 fraction, one extra integer bit so 1.0 is representable
	localparam int FRAC_BITS = 16;
	localparam int QUOT_W    = FRAC_BITS + 1;
	localparam int DIV_STEPS = QUOT_W;
	localparam int PROD_W    = QUOT_W + LEN_W;

	typedef struct packed {
		logic [CIDX_W-1:0]   cell_index;
		logic signed [V_W-1:0] old_voltage;
		logic signed [V_W-1:0] new_voltage;
		logic [START_W-1:0]  step_start_time;
		logic [LEN_W-1:0]    step_length;
	} item_t;

	typedef struct packed {
		logic             crossed;
		logic [ACT_W-1:0] activation_time;
	} result_t;

endpackage

// ----- sv/activation_time_crossing_detector.sv -----
// Activation time crossing detector.
// Item channel (item_valid / item_stall / item): one beat per cell and time step,
// carrying the cell index, voltages before and after the step, step start and length.
// Result channel (result_valid / result_stall / result): exactly one beat per item,
// in order; crossed is set when an armed cell rose through the threshold, and
// activation_time is start + fraction * length (0 when not crossed).
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the signed threshold;
// cfg_ready is always high. Write it only while no items are in flight.
// Throughput: one item per cycle unless result_stall or the clearing pass stalls input.
// The result beat is registered through stage 1 (flag read), the divider input stage,
// the 17-stage restoring divider (one quotient bit per stage), multiply and add stages.
// Reset: clears the pipeline and threshold, then a clearing pass re-arms all
// NUM_CELLS flags in the flag RAM, one per cycle; item_stall is
// high for the whole pass.
// Stall: when result_stall holds a waiting result, the whole pipeline freezes and
// item_stall is raised in the same cycle; nothing is dropped or repeated.
module activation_time_crossing_detector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  atcd_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output atcd_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [atcd_pkg::V_W-1:0]     cfg_data
);

	import atcd_pkg::*;

	logic                  pipe_en;
	logic                  item_acc;
	logic signed [V_W-1:0] threshold_q;
	logic                  clr_busy_q;
	logic [CELL_AW-1:0]    clr_addr_q;

	logic                  ram_we;
	logic [CELL_AW-1:0]    ram_waddr;
	logic [0:0]            ram_wdata;
	logic [0:0]            ram_rdata;

	logic                  s1_valid;
	item_t                 s1_item;
	logic                  s1_kill;
	logic                  s1_in_range;
	logic                  s1_armed;
	logic                  s1_rising;
	logic                  s1_cross;
	logic                  s1_wr;
	logic signed [V_W:0]   s1_num;
	logic signed [V_W:0]   s1_den;

	// Divider pipeline; entry 0 is stage 2
	logic                  div_v_s     [0:DIV_STEPS];
	logic                  div_x_s     [0:DIV_STEPS];
	logic [V_W-1:0]        div_rem_s   [0:DIV_STEPS];
	logic [V_W-1:0]        div_den_s   [0:DIV_STEPS];
	logic [QUOT_W-1:0]     div_q_s     [0:DIV_STEPS];
	logic [START_W-1:0]    div_start_s [0:DIV_STEPS];
	logic [LEN_W-1:0]      div_len_s   [0:DIV_STEPS];

	logic                  mul_v_s;
	logic                  mul_x_s;
	logic [PROD_W-1:0]     mul_prod_s;
	logic [START_W-1:0]    mul_start_s;
	logic [ACT_W-1:0]      act_sum;

	logic                  result_valid_q;
	result_t               result_q;

	// Global advance: everything moves unless a finished beat is held
	assign pipe_en    = !result_valid_q || !result_stall;
	assign item_stall = !pipe_en || clr_busy_q;
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_valid) begin
			threshold_q <= $signed(cfg_data);
		end
	end

	// Post-reset clearing pass: re-arm every cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == CELL_AW'(NUM_CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Armed flag store, shared write port for clearing and disarming
	assign ram_we    = clr_busy_q || s1_wr;
	assign ram_waddr = clr_busy_q ? clr_addr_q : s1_item.cell_index[CELL_AW-1:0];
	assign ram_wdata = clr_busy_q ? 1'b1 : 1'b0;

	atcd_ram #(
		.WIDTH (1),
		.DEPTH (NUM_CELLS)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (item_acc),
		.raddr (item.cell_index[CELL_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Stage 1: flag read lands, crossing test, disarm write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_kill  <= 1'b0;
		end else if (pipe_en) begin
			s1_valid <= item_acc;
			// flag read raced the disarm of the previous beat on the same cell
			s1_kill  <= s1_wr && (item.cell_index == s1_item.cell_index);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			s1_item <= item;
		end
	end

	always_comb begin
		s1_in_range = {1'b0, s1_item.cell_index} < (CIDX_W + 1)'(NUM_CELLS);
		s1_armed    = ram_rdata[0] && !s1_kill;
		s1_rising   = (s1_item.old_voltage < threshold_q) &&
		              (s1_item.new_voltage >= threshold_q);
		s1_cross    = s1_in_range && s1_armed && s1_rising;
		s1_wr       = pipe_en && s1_valid && s1_cross;
		s1_num      = {threshold_q[V_W-1], threshold_q} -
		              {s1_item.old_voltage[V_W-1], s1_item.old_voltage};
		s1_den      = {s1_item.new_voltage[V_W-1], s1_item.new_voltage} -
		              {s1_item.old_voltage[V_W-1], s1_item.old_voltage};
	end

	// Stage 2: divider input (num <= den on a crossing, both fit unsigned V_W)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (pipe_en) begin
			div_v_s[0] <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			div_x_s[0]     <= s1_cross;
			div_rem_s[0]   <= s1_num[V_W-1:0];
			div_den_s[0]   <= s1_den[V_W-1:0];
			div_q_s[0]     <= '0;
			div_start_s[0] <= s1_item.step_start_time;
			div_len_s[0]   <= s1_item.step_length;
		end
	end

	// Restoring divider, one quotient bit per stage, integer bit first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [V_W:0] trial;
		logic [V_W:0] diff;
		logic         ge;

		always_comb begin
			trial = (k == 0) ? {1'b0, div_rem_s[k]} : {div_rem_s[k], 1'b0};
			diff  = trial - {1'b0, div_den_s[k]};
			ge    = trial >= {1'b0, div_den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (pipe_en) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				div_x_s[k+1]     <= div_x_s[k];
				div_rem_s[k+1]   <= ge ? diff[V_W-1:0] : trial[V_W-1:0];
				div_den_s[k+1]   <= div_den_s[k];
				div_q_s[k+1]     <= {div_q_s[k][QUOT_W-2:0], ge};
				div_start_s[k+1] <= div_start_s[k];
				div_len_s[k+1]   <= div_len_s[k];
			end
		end
	end

	// Multiply stage: fraction times step length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s <= 1'b0;
		end else if (pipe_en) begin
			mul_v_s <= div_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mul_x_s     <= div_x_s[DIV_STEPS];
			mul_prod_s  <= PROD_W'(div_q_s[DIV_STEPS]) * PROD_W'(div_len_s[DIV_STEPS]);
			mul_start_s <= div_start_s[DIV_STEPS];
		end
	end

	// Output stage: truncate offset and add to start
	assign act_sum = ACT_W'(mul_start_s) + ACT_W'(mul_prod_s[PROD_W-1:FRAC_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pipe_en) begin
			result_valid_q <= mul_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			result_q.crossed         <= mul_x_s;
			result_q.activation_time <= mul_x_s ? act_sum : '0;
		end
	end

`ifndef SYNTHESIS
	// No item enters while the flag store is being re-armed
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> item_stall)
		else $error("item accepted during clearing pass");

	// Divider precondition on a crossing beat
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_v_s[0] && div_x_s[0]) |->
			(div_rem_s[0] <= div_den_s[0]) && (div_den_s[0] != '0))
		else $error("crossing with numerator above denominator");

	// Fraction never exceeds 1.0
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_v_s[DIV_STEPS] && div_x_s[DIV_STEPS]) |->
			(div_q_s[DIV_STEPS] <= QUOT_W'(1 << FRAC_BITS)))
		else $error("crossing fraction above one");

	// A disarm write only happens on a moving pipeline, never during clearing
	a_disarm_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		s1_wr |-> (pipe_en && !clr_busy_q))
		else $error("disarm write outside normal operation");

	// Non-crossed beats carry a zero time
	a_zero_time: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.crossed) |-> (result.activation_time == '0))
		else $error("non-crossed result with nonzero time");
`endif

endmodule

// ----- sv/atcd_ram.sv -----
module atcd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// One write port, one registered read port (read returns old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
